### rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// shared types and constants for the double-ended queue unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DQ_DEPTH = 16;
  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_CLEAR      = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOAD = 1'b1
  } state_t;

endpackage

### rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// slot memory: one write port, two registered read ports, write-first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_ram #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH,
  parameter int WIDTH = dq_pkg::WORD_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic             re,
  input  logic [AW-1:0]    ra0,
  input  logic [AW-1:0]    ra1,
  output logic [WIDTH-1:0] rd0,
  output logic [WIDTH-1:0] rd1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // a read of the entry written in the same cycle returns the new word
  always_ff @(posedge clk) begin
    if (re) begin
      rd0 <= (we && wa == ra0) ? wd : mem[ra0];
      rd1 <= (we && wa == ra1) ? wd : mem[ra1];
    end
  end

endmodule

### rtl/double_ended_queue_unit.sv
// an accepted item takes the unit to its load state; the result is registered
//   from there once the output register is empty or being read, and no new item
//   is taken until then; the load uses the slot memory read after the pointer update
// a finished result waits in the output register while the next item is taken
// reset: synchronous; pointers and count go to zero, slot contents stay as is
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// bounded double-ended queue of signed words held in a ring of slots
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue_unit #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic [2:0]  s_axis_tuser,   // operation[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], front_value[33:2], rear_value[65:34], count[70:66], is_empty[71]
  output logic [71:0] m_axis_tdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CNT_W = dq_pkg::CNT_W;
  localparam int WORD_W = dq_pkg::WORD_W;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL = OCC_W'(DEPTH);

  dq_pkg::state_t state, state_next;

  logic [PTR_W-1:0] front_ptr, front_ptr_next;
  logic [PTR_W-1:0] rear_ptr, rear_ptr_next;
  logic [OCC_W-1:0] occupancy, occupancy_next;
  dq_pkg::status_t  status_next;
  dq_pkg::status_t  pend_status;
  logic [OCC_W-1:0] pend_occ;

  logic             accept;
  logic             load_out;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] rear_last;
  logic [WORD_W-1:0] rd_front, rd_rear;

  logic              out_valid;
  logic [1:0]        out_status;
  logic [WORD_W-1:0] out_front, out_rear;
  logic [CNT_W-1:0]  out_count;
  logic              out_empty;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST : p - 1'b1;
  endfunction

  assign accept = s_axis_tvalid && s_axis_tready;

  // pointer and count update for the item on the input side
  always_comb begin
    front_ptr_next = front_ptr;
    rear_ptr_next  = rear_ptr;
    occupancy_next = occupancy;
    status_next    = dq_pkg::ST_OK;
    wr_en          = 1'b0;
    wr_addr        = rear_ptr;
    case (dq_pkg::op_t'(s_axis_tuser))
      dq_pkg::OP_PUSH_FRONT: begin
        if (occupancy >= FULL) begin
          status_next = dq_pkg::ST_OVERFLOW;
        end else begin
          front_ptr_next = ring_prev(front_ptr);
          wr_addr        = front_ptr_next;
          wr_en          = accept;
          occupancy_next = occupancy + 1'b1;
        end
      end
      dq_pkg::OP_PUSH_REAR: begin
        if (occupancy >= FULL) begin
          status_next = dq_pkg::ST_OVERFLOW;
        end else begin
          wr_addr        = rear_ptr;
          wr_en          = accept;
          rear_ptr_next  = ring_next(rear_ptr);
          occupancy_next = occupancy + 1'b1;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (occupancy == '0) begin
          status_next = dq_pkg::ST_UNDERFLOW;
        end else begin
          front_ptr_next = ring_next(front_ptr);
          occupancy_next = occupancy - 1'b1;
        end
      end
      dq_pkg::OP_POP_REAR: begin
        if (occupancy == '0) begin
          status_next = dq_pkg::ST_UNDERFLOW;
        end else begin
          rear_ptr_next  = ring_prev(rear_ptr);
          occupancy_next = occupancy - 1'b1;
        end
      end
      dq_pkg::OP_CLEAR: begin
        front_ptr_next = '0;
        rear_ptr_next  = '0;
        occupancy_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign rear_last = ring_prev(rear_ptr_next);

  dq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk (clk),
    .we  (wr_en),
    .wa  (wr_addr),
    .wd  (s_axis_tdata),
    .re  (accept),
    .ra0 (front_ptr_next),
    .ra1 (rear_last),
    .rd0 (rd_front),
    .rd1 (rd_rear)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dq_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = dq_pkg::ST_LOAD;
        end
      end
      dq_pkg::ST_LOAD: begin
        if (load_out) begin
          state_next = dq_pkg::ST_IDLE;
        end
      end
      default: state_next = dq_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (state)
      dq_pkg::ST_IDLE: s_axis_tready = 1'b1;
      dq_pkg::ST_LOAD: load_out = !out_valid || m_axis_tready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dq_pkg::ST_IDLE;
      front_ptr <= '0;
      rear_ptr  <= '0;
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        front_ptr <= front_ptr_next;
        rear_ptr  <= rear_ptr_next;
        occupancy <= occupancy_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign occ_ext = {{CNT_W{1'b0}}, pend_occ};

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
      pend_occ    <= occupancy_next;
    end
    if (load_out) begin
      out_status <= pend_status;
      out_empty  <= (pend_occ == '0);
      out_count  <= occ_ext[CNT_W-1:0];
      out_front  <= (pend_occ == '0) ? '1 : rd_front;
      out_rear   <= (pend_occ == '0) ? '1 : rd_rear;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_empty, out_count, out_rear, out_front, out_status};

  // ring consistency: rear sits occupancy slots past front
  logic [PTR_W:0] ptr_sum;
  logic [PTR_W:0] ptr_wrap;
  logic [PTR_W-1:0] rear_expect;
  assign ptr_sum     = {1'b0, front_ptr} + (PTR_W+1)'(occupancy);
  assign ptr_wrap    = ptr_sum - (PTR_W+1)'(DEPTH);
  assign rear_expect = (ptr_sum >= (PTR_W+1)'(DEPTH)) ? ptr_wrap[PTR_W-1:0]
                                                       : ptr_sum[PTR_W-1:0];

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= FULL)
    else $error("occupancy above depth");

  a_ring: assert property (@(posedge clk) disable iff (rst)
    (occupancy == FULL) || (rear_ptr == (PTR_W)'(front_ptr + occupancy)) ||
    (rear_ptr == rear_expect))
    else $error("front, rear and occupancy disagree");

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == dq_pkg::ST_LOAD))
    else $error("accepted item not taken to load");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_status == dq_pkg::ST_UNDERFLOW) |-> out_empty)
    else $error("underflow reported on a non-empty queue");

endmodule

### tb/tb_double_ended_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_unit
// Streams push, pop, clear and unused operations into the double-ended queue.
// A built-in ring model predicts every status, front, rear and count. Both
// sides of the stream idle at random, and the result side holds off long
// enough to back the input up.
// ----------------------------------------------------------------------------

module tb_double_ended_queue_unit;
  import dq_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_CYCLES  = 250;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] word;
  } dq_item_t;

  typedef struct {
    status_t           status;
    logic [WORD_W-1:0] front;
    logic [WORD_W-1:0] rear;
    logic [CNT_W-1:0]  count;
    logic              empty;
  } dq_result_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // value[31:0]
  logic [2:0]  s_axis_tuser  = '0;  // operation[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status[1:0], front_value[33:2], rear_value[65:34], count[70:66], is_empty[71]
  logic [71:0] m_axis_tdata;

  dq_item_t   op_items_q[$];
  dq_result_t dq_result_q[$];

  // ring model of the queue
  logic [WORD_W-1:0] model_slots [DQ_DEPTH];
  int head_ptr   = 0;
  int tail_ptr   = 0;
  int fill_level = 0;

  int error_count  = 0;
  int result_index = 0;
  int cycle_count  = 0;
  int hold_left    = 0;
  int send_gap     = 0;
  int recv_gap     = 0;
  logic no_idle    = 1'b0;
  logic hold_busy;

  assign hold_busy = (hold_left > 0);

  double_ended_queue_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic dq_result_t deque_apply(dq_item_t it);
    dq_result_t r;
    r.status = ST_OK;
    case (it.op)
      OP_PUSH_FRONT: begin
        if (fill_level >= DQ_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          head_ptr = (head_ptr + DQ_DEPTH - 1) % DQ_DEPTH;
          model_slots[head_ptr] = it.word;
          fill_level++;
        end
      end
      OP_PUSH_REAR: begin
        if (fill_level >= DQ_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          model_slots[tail_ptr] = it.word;
          tail_ptr = (tail_ptr + 1) % DQ_DEPTH;
          fill_level++;
        end
      end
      OP_POP_FRONT: begin
        if (fill_level == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          head_ptr = (head_ptr + 1) % DQ_DEPTH;
          fill_level--;
        end
      end
      OP_POP_REAR: begin
        if (fill_level == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          tail_ptr = (tail_ptr + DQ_DEPTH - 1) % DQ_DEPTH;
          fill_level--;
        end
      end
      OP_CLEAR: begin
        head_ptr   = 0;
        tail_ptr   = 0;
        fill_level = 0;
      end
      default: ;
    endcase
    if (fill_level == 0) begin
      r.front = '1;
      r.rear  = '1;
    end else begin
      r.front = model_slots[head_ptr];
      r.rear  = model_slots[(tail_ptr + DQ_DEPTH - 1) % DQ_DEPTH];
    end
    r.count = CNT_W'(fill_level);
    r.empty = (fill_level == 0);
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (no_idle) return 0;
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_item(logic [OP_W-1:0] op, logic [WORD_W-1:0] word);
    dq_item_t it;
    it.op   = op;
    it.word = word;
    op_items_q.push_back(it);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got %h expected %h", result_index, what, got, want);
    error_count++;
  endtask

  task automatic check_result();
    dq_result_t want;
    if (dq_result_q.size() == 0) begin
      report_mismatch("unexpected item", m_axis_tdata[33:2], '0);
      return;
    end
    want = dq_result_q.pop_front();
    if (m_axis_tdata[1:0] !== want.status)
      report_mismatch("status", 32'(m_axis_tdata[1:0]), 32'(want.status));
    if (m_axis_tdata[33:2] !== want.front)
      report_mismatch("front_value", m_axis_tdata[33:2], want.front);
    if (m_axis_tdata[65:34] !== want.rear)
      report_mismatch("rear_value", m_axis_tdata[65:34], want.rear);
    if (m_axis_tdata[70:66] !== want.count)
      report_mismatch("count", 32'(m_axis_tdata[70:66]), 32'(want.count));
    if (m_axis_tdata[71] !== want.empty)
      report_mismatch("is_empty", 32'(m_axis_tdata[71]), 32'(want.empty));
    result_index++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        dq_result_q.push_back(deque_apply(op_items_q.pop_front()));
        send_gap = pick_gap();
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (op_items_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= op_items_q[0].op;
          s_axis_tdata  <= op_items_q[0].word;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (hold_busy) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        recv_gap = pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // cycle count, long receiver hold-off, idle-free stretches, timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == 400 || cycle_count == 3000) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
    if (cycle_count % 300 == 0) no_idle <= ($urandom_range(0, 3) == 0);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int bias;
    int push_pct;
    logic [OP_W-1:0] op;

    // pops and an unused code on the empty queue, then pushes and pops at both ends
    queue_item(OP_POP_FRONT, 32'h1234_5678);
    queue_item(OP_POP_REAR, 32'hffff_ffff);
    queue_item(3'd5, 32'h0);
    queue_item(OP_PUSH_FRONT, 32'h8000_0000);
    queue_item(OP_PUSH_REAR, 32'h7fff_ffff);
    queue_item(OP_POP_FRONT, 32'h0);
    queue_item(OP_POP_REAR, 32'h0);
    // fill to the top, then push past it on both ends, then unused codes and a clear
    for (int k = 0; k < DQ_DEPTH; k++)
      queue_item((k % 2) ? OP_PUSH_REAR : OP_PUSH_FRONT, random_word());
    queue_item(OP_PUSH_FRONT, 32'h5555_5555);
    queue_item(OP_PUSH_REAR, 32'haaaa_aaaa);
    queue_item(3'd6, 32'hffff_ffff);
    queue_item(3'd7, 32'h0);
    queue_item(OP_CLEAR, 32'h0);

    bias = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // pick filling, draining or balanced runs at random so both ends get hit
      if (i % 40 == 0) bias = $urandom_range(0, 2);
      push_pct = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
      if ($urandom_range(0, 99) < 2) begin
        op = OP_CLEAR;
      end else if ($urandom_range(0, 99) < 3) begin
        op = OP_W'($urandom_range(5, 7));
      end else if ($urandom_range(0, 99) < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
      end
      queue_item(op, random_word());
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (op_items_q.size() > 0 || dq_result_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
